/* rtl/bole_pkg.sv */
// package: shared constants and codes for the bounded ordered list engine
`timescale 1ns / 1ps
package bole_pkg;

  localparam int BOLE_CAPACITY = 32;
  localparam int BOLE_DATA_W   = 16;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_SORT = 3'd2,
    OP_SORT     = 3'd3,
    OP_READ_FWD = 3'd4,
    OP_READ_BWD = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

/* rtl/bole_ram.sv */
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module bole_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bounded_ordered_list_engine.sv */
// top level: bounded ordered list engine with a ram store and a small sequencer
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------
//  input    | in_valid / in_ready | op, value
//  output   | out_valid/out_ready | data, status, entries, last
//
// one item at a time; in_ready is high only while the sequencer is idle
// refused insert, empty read, unknown op, sort of fewer than two entries: straight to the result
// insert: a sorted insert scans for its slot; entries past the slot move up one each
// sort: bubble passes, each one entry shorter, until no swap; read: one result per entry
// every step is paced by the one ram read port with its registered read data
// output stalls hold the sequencer; rst clears the count and the sequencer
`timescale 1ns / 1ps
module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int CAPACITY = BOLE_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    op,
  input  logic signed [BOLE_DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [BOLE_DATA_W-1:0] data,
  output logic [1:0]                    status,
  output logic [5:0]                    entries,
  output logic                          last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [12:0] {
    S_IDLE     = 13'h0001,
    S_SCAN_RD  = 13'h0002,
    S_SCAN_CMP = 13'h0004,
    S_SH_RD    = 13'h0008,
    S_SH_WR    = 13'h0010,
    S_SO_LOAD  = 13'h0020,
    S_SO_LOADW = 13'h0040,
    S_SO_RD    = 13'h0080,
    S_SO_CMP   = 13'h0100,
    S_RD_ISSUE = 13'h0200,
    S_RD_WAIT  = 13'h0400,
    S_RD_OUT   = 13'h0800,
    S_RESP     = 13'h1000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]                 count;
  logic [CW-1:0]                 pos;
  logic [CW-1:0]                 idx;
  logic [CW-1:0]                 lim;
  logic signed [BOLE_DATA_W-1:0] vreg;
  logic signed [BOLE_DATA_W-1:0] carry;
  logic                          change;
  logic                          fwd;

  logic [CW-1:0]                 idx_m1;
  logic [CW-1:0]                 idx_p1;
  logic [CW-1:0]                 rd_pos;
  status_t                       resp_status;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [BOLE_DATA_W-1:0]        wdata;
  logic [AW-1:0]                 raddr;
  logic [BOLE_DATA_W-1:0]        rdata;

  assign idx_m1   = idx - 1'b1;
  assign idx_p1   = idx + 1'b1;
  assign rd_pos   = fwd ? idx : (count - idx - 1'b1);
  assign in_ready = (state == S_IDLE);
  assign entries  = 6'(count);

  bole_ram #(
    .WIDTH (BOLE_DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next  = state;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    resp_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op) inside
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_SORT: begin
              if (count >= CAP) begin
                resp_status = ST_FULL;
                state_next  = S_RESP;
              end else if (op == OP_INS_SORT) begin
                state_next = S_SCAN_RD;
              end else begin
                state_next = S_SH_RD;
              end
            end
            OP_SORT: begin
              state_next = (count > CW'(1)) ? S_SO_LOAD : S_RESP;
            end
            OP_READ_FWD, OP_READ_BWD: begin
              if (count == '0) begin
                resp_status = ST_EMPTY;
                state_next  = S_RESP;
              end else begin
                state_next = S_RD_ISSUE;
              end
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_SCAN_RD: begin
        raddr = pos[AW-1:0];
        state_next = (pos == count) ? S_SH_RD : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_next = ($signed(rdata) < vreg) ? S_SCAN_RD : S_SH_RD;
      end
      S_SH_RD: begin
        if (idx == pos) begin
          we         = 1'b1;
          waddr      = pos[AW-1:0];
          wdata      = vreg;
          state_next = S_RESP;
        end else begin
          raddr      = idx_m1[AW-1:0];
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        wdata      = rdata;
        state_next = S_SH_RD;
      end
      S_SO_LOAD: begin
        state_next = S_SO_LOADW;
      end
      S_SO_LOADW: begin
        state_next = S_SO_RD;
      end
      S_SO_RD: begin
        if (idx == lim) begin
          we         = 1'b1;
          waddr      = lim[AW-1:0];
          wdata      = carry;
          state_next = (change && lim > CW'(1)) ? S_SO_LOAD : S_RESP;
        end else begin
          raddr      = idx_p1[AW-1:0];
          state_next = S_SO_CMP;
        end
      end
      S_SO_CMP: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        wdata      = (carry > $signed(rdata)) ? rdata : carry;
        state_next = S_SO_RD;
      end
      S_RD_ISSUE: begin
        raddr      = rd_pos[AW-1:0];
        state_next = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (out_ready) begin
          state_next = last ? S_IDLE : S_RD_ISSUE;
        end
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // single result for every op that is not a non-empty read
      if (state_next == S_RESP && state != S_RESP) begin
        out_valid <= 1'b1;
        data      <= '0;
        status    <= resp_status;
        last      <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          vreg   <= value;
          idx    <= (op == OP_INS_HEAD || op == OP_INS_SORT ||
                     op == OP_INS_TAIL) ? count : '0;
          pos    <= (op == OP_INS_TAIL) ? count : '0;
          lim    <= count - 1'b1;
          fwd    <= (op == OP_READ_FWD);
          change <= 1'b0;
        end
        S_SCAN_RD: begin
        end
        S_SCAN_CMP: begin
          if ($signed(rdata) < vreg) begin
            pos <= pos + 1'b1;
          end
        end
        S_SH_RD: begin
          if (idx == pos) begin
            count <= count + 1'b1;
          end
        end
        S_SH_WR: begin
          idx <= idx_m1;
        end
        S_SO_LOAD: begin
          idx    <= '0;
          change <= 1'b0;
        end
        S_SO_LOADW: begin
          carry <= rdata;
        end
        S_SO_RD: begin
          if (idx == lim) begin
            lim <= lim - 1'b1;
          end
        end
        S_SO_CMP: begin
          if (carry > $signed(rdata)) begin
            change <= 1'b1;
          end else begin
            carry <= rdata;
          end
          idx <= idx_p1;
        end
        S_RD_ISSUE: begin
        end
        S_RD_WAIT: begin
          out_valid <= 1'b1;
          data      <= rdata;
          status    <= ST_OK;
          last      <= (idx_p1 == count);
        end
        S_RD_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            idx       <= idx_p1;
          end
        end
        S_RESP: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // no result may wait while the sequencer takes a new item
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("result pending while idle");

  // the list never grows past its capacity
  assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count above capacity");

  // a refused insert is only reported with a full list
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == CAP))
    else $error("full status with room left");

  // a finished insert grows the list by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_RD && idx == pos) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the list");

endmodule
